// ===== sv/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and constants for the radial cupping artifact core.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int DAT_W   = 24;

    typedef enum logic [IDX_W-1:0] {
        CFG_COLUMNS,
        CFG_ROWS,
        CFG_SPACING_X,
        CFG_SPACING_Y,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_INV_MAX_DISTANCE,
        CFG_MIN_FACTOR
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0]        columns;
        logic [12:0]        rows;
        logic [23:0]        spacing_x;
        logic [23:0]        spacing_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [31:0]        inv_max_distance;
        logic [17:0]        min_factor;
    } t_cfg;

    typedef struct packed {
        logic signed [DAT_W-1:0] dens;
        logic signed [DAT_W-1:0] prior;
        logic [DIM_W-1:0]        col;
        logic [DIM_W-1:0]        row;
    } t_job;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_queue_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS_X,
        ST_AXIS_Y,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_REL,
        ST_FAC,
        ST_DEL,
        ST_OUT
    } t_state;

endpackage

// ===== sv/rca_in_if.sv =====
// ----------------------------------------------------------------------------
// rca_in_if
// Input item channel: voxel density and prior artifact.
// ----------------------------------------------------------------------------
interface rca_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] radiodensity;
    logic signed [23:0] prior_artifact;

    modport source (output valid, radiodensity, prior_artifact, input ready);
    modport sink   (input valid, radiodensity, prior_artifact, output ready);
endinterface

// ===== sv/rca_out_if.sv =====
// ----------------------------------------------------------------------------
// rca_out_if
// Result item channel: corrected density, artifact total and delta.
// ----------------------------------------------------------------------------
interface rca_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] new_radiodensity;
    logic signed [23:0] artifact_total;
    logic signed [23:0] artifact_delta;

    modport source (output valid, new_radiodensity, artifact_total, artifact_delta,
                    input ready);
    modport sink   (input valid, new_radiodensity, artifact_total, artifact_delta,
                    output ready);
endinterface

// ===== sv/rca_front.sv =====
// ----------------------------------------------------------------------------
// rca_front
// Accepts items, tags them with column/row position, queues them (2 deep).
// ----------------------------------------------------------------------------
module rca_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [12:0]           i_columns,
    input  logic [12:0]           i_rows,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [23:0]    i_dens,
    input  logic signed [23:0]    i_prior,
    input  logic                  i_pop,
    output rca_pkg::t_queue_ctl   o_ctl,
    output rca_pkg::t_job         o_job
);
    import rca_pkg::*;

    t_job             r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic [DIM_W-1:0] r_col, r_row, n_col, n_row;
    logic [DIM_W:0]   lc, lr;
    logic             acc, pop;

    function automatic logic [DIM_W:0] dim_limit(input logic [12:0] v);
        if (v == 13'd0) return (DIM_W+1)'(1);
        if (32'(v) > MAX_DIM) return (DIM_W+1)'(MAX_DIM);
        return (DIM_W+1)'(v);
    endfunction

    assign lc      = dim_limit(i_columns);
    assign lr      = dim_limit(i_rows);
    assign o_ready = (r_cnt != 2'd2);
    assign acc     = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);
    assign o_ctl.valid = (r_cnt != 2'd0);
    assign o_ctl.pop   = pop;
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if ({1'b0, r_col} + 1'b1 >= lc) begin
            n_col = '0;
            if ({1'b0, r_row} + 1'b1 >= lr) begin
                n_row = '0;
            end else begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
        n_cnt = r_cnt + {1'b0, acc} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
                r_wp  <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mem[r_wp] <= '{dens: i_dens, prior: i_prior, col: r_col, row: r_row};
        end
    end

endmodule

// ===== sv/rca_back.sv =====
// ----------------------------------------------------------------------------
// rca_back
// Sequential datapath: distance, bit-serial square root, factor and delta.
// ----------------------------------------------------------------------------
module rca_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rca_pkg::t_cfg        i_cfg,
    input  rca_pkg::t_queue_ctl  i_ctl,
    input  rca_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [23:0]   o_new_dens,
    output logic signed [23:0]   o_total,
    output logic signed [23:0]   o_delta
);
    import rca_pkg::*;

    t_state             r_state, n_state;
    t_job               r_job;
    logic [30:0]        r_ax, r_ay;
    logic [62:0]        r_acc;
    logic [63:0]        r_x, r_res, r_bit;
    logic [4:0]         r_it;
    logic [63:0]        r_prod;
    logic signed [29:0] r_f16;
    logic signed [23:0] r_dl;
    logic               r_ov;
    logic signed [23:0] r_o_nd, r_o_tot, r_o_dl;

    logic               out_free, load;
    logic [63:0]        trial;
    logic [32:0]        relw;
    logic [23:0]        rel24;
    logic signed [45:0] f;
    logic signed [53:0] p;
    logic [30:0]        sq_in;
    logic [61:0]        sq;

    function automatic logic [30:0] axis_abs(input logic signed [31:0] off,
                                             input logic [DIM_W-1:0] pos,
                                             input logic [23:0] sp);
        logic [DIM_W+23:0]        prod;
        logic signed [DIM_W+25:0] d;
        logic [DIM_W+25:0]        a;
        prod = pos * sp;
        d = $signed({2'b00, prod}) + (DIM_W+26)'(off);
        a = d[DIM_W+25] ? $unsigned(-d) : $unsigned(d);
        if (a > (DIM_W+26)'(32'h7FFF_FFFF)) return 31'h7FFF_FFFF;
        return a[30:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [55:0] v);
        if (v > 56'sd8388607) return 24'sh7FFFFF;
        if (v < -56'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    assign out_free = !r_ov || i_ready;
    assign trial    = r_res + r_bit;
    assign relw     = 33'((r_prod + 64'h8000_0000) >> 32);
    assign rel24    = (relw > 33'hFF_FFFF) ? 24'hFF_FFFF : relw[23:0];
    assign f        = ($signed({2'b00, rel24}) - 26'sd65536)
                    * (20'sd65536 - $signed({2'b00, i_cfg.min_factor}));
    assign p        = r_job.dens * r_f16;
    assign sq_in    = (r_state == ST_SQ_X) ? r_ax : r_ay;
    assign sq       = sq_in * sq_in;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_AXIS_X;
                end
            end
            ST_AXIS_X: n_state = ST_AXIS_Y;
            ST_AXIS_Y: n_state = ST_SQ_X;
            ST_SQ_X:   n_state = ST_SQ_Y;
            ST_SQ_Y:   n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_it == 5'd0) n_state = ST_REL;
            end
            ST_REL:    n_state = ST_FAC;
            ST_FAC:    n_state = ST_DEL;
            ST_DEL:    n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE:   r_job <= i_job;
            ST_AXIS_X: r_ax <= axis_abs(i_cfg.offset_x, r_job.col, i_cfg.spacing_x);
            ST_AXIS_Y: r_ay <= axis_abs(i_cfg.offset_y, r_job.row, i_cfg.spacing_y);
            ST_SQ_X:   r_acc <= {1'b0, sq};
            ST_SQ_Y: begin
                r_x   <= {1'b0, r_acc + {1'b0, sq}};
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
                r_it  <= 5'd31;
            end
            ST_SQRT: begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_it  <= r_it - 1'b1;
            end
            ST_REL:    r_prod <= r_res[31:0] * i_cfg.inv_max_distance;
            ST_FAC:    r_f16 <= 30'((f + 46'sd32768) >>> 16);
            ST_DEL:    r_dl <= sat24(56'((56'(p) + 56'sd32768) >>> 16));
            ST_OUT: begin
                if (load) begin
                    r_o_nd  <= sat24(56'(r_job.dens) + 56'(r_dl));
                    r_o_tot <= sat24(56'(r_job.prior) + 56'(r_dl));
                    r_o_dl  <= r_dl;
                end
            end
            default: ;
        endcase
    end

    assign o_valid    = r_ov;
    assign o_new_dens = r_o_nd;
    assign o_total    = r_o_tot;
    assign o_delta    = r_o_dl;

endmodule

// ===== sv/radial_cupping_artifact_core.sv =====
// ----------------------------------------------------------------------------
// radial_cupping_artifact_core
// Radial cupping artifact applied to a raster voxel stream.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | radiodensity, prior_artifact
//  out_ch   | out | valid/ready   | new_radiodensity, artifact_total, artifact_delta
//  cfg      | in  | i_cfg_we      | i_cfg_idx, i_cfg_data
//
//  The 32-step square root is the longest part of an item's pass through the back end.
//  Front queue holds 2 items, so input is taken while the back end works.
//  Reset clears counters, queue and output valid; no clearing pass.
//  Output register holds a result under stall; back end waits on it.
// ----------------------------------------------------------------------------
module radial_cupping_artifact_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rca_in_if.sink                      in_ch,
    rca_out_if.source                   out_ch,
    input  logic                        i_cfg_we,
    input  logic [rca_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rca_pkg::CFG_W-1:0]   i_cfg_data
);
    import rca_pkg::*;

    t_cfg       r_cfg;
    t_queue_ctl ctl;
    t_job       job;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns          <= 13'd512;
            r_cfg.rows             <= 13'd512;
            r_cfg.spacing_x        <= 24'd65536;
            r_cfg.spacing_y        <= 24'd65536;
            r_cfg.offset_x         <= '0;
            r_cfg.offset_y         <= '0;
            r_cfg.inv_max_distance <= '0;
            r_cfg.min_factor       <= 18'd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COLUMNS:          r_cfg.columns          <= i_cfg_data[12:0];
                CFG_ROWS:             r_cfg.rows             <= i_cfg_data[12:0];
                CFG_SPACING_X:        r_cfg.spacing_x        <= i_cfg_data[23:0];
                CFG_SPACING_Y:        r_cfg.spacing_y        <= i_cfg_data[23:0];
                CFG_OFFSET_X:         r_cfg.offset_x         <= $signed(i_cfg_data);
                CFG_OFFSET_Y:         r_cfg.offset_y         <= $signed(i_cfg_data);
                CFG_INV_MAX_DISTANCE: r_cfg.inv_max_distance <= i_cfg_data;
                CFG_MIN_FACTOR:       r_cfg.min_factor       <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    rca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_columns (r_cfg.columns),
        .i_rows  (r_cfg.rows),
        .i_valid (in_ch.valid),
        .o_ready (in_ch.ready),
        .i_dens  (in_ch.radiodensity),
        .i_prior (in_ch.prior_artifact),
        .i_pop   (pop),
        .o_ctl   (ctl),
        .o_job   (job)
    );

    rca_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ctl      (ctl),
        .i_job      (job),
        .o_pop      (pop),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_new_dens (out_ch.new_radiodensity),
        .o_total    (out_ch.artifact_total),
        .o_delta    (out_ch.artifact_delta)
    );

endmodule

// ===== sv/rca_checker.sv =====
// ----------------------------------------------------------------------------
// rca_checker
// Port-level checks on the radial cupping artifact core.
// ----------------------------------------------------------------------------
module rca_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [23:0] i_out_delta,
    input logic signed [23:0] i_out_dens
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_delta)
                                         && $stable(i_out_dens))
        else $error("stalled result changed");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_delta, i_out_dens}))
        else $error("result item carries unknown bits");
endmodule

bind radial_cupping_artifact_core rca_checker u_rca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_out_delta (out_ch.artifact_delta),
    .i_out_dens  (out_ch.new_radiodensity)
);
